@@ rtl/fsf_pkg.sv @@
package fsf_pkg;

	localparam int MAX_TAPS_DEF = 256;
	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 16;
	localparam int INDEX_W      = 8;
	localparam int CFG_W        = 9;
	localparam int PROD_W       = SAMPLE_W + COEF_W;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_FILTER = 1'b1;

	// controls shared by every cell of the chain
	typedef struct packed {
		logic load;
		logic shift;
		logic rotate;
	} cell_ctl_t;

	typedef struct packed {
		logic clear;
		logic take;
	} mac_ctl_t;

endpackage

@@ rtl/fir_sample_filter.sv @@
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   req_type, coef_index, coef_value, sample_in
// out      output     out_valid/out_stall sample_out, clipped
// cfg      input      cfg_valid/cfg_ready cfg_data (tap_count)
//
// a coefficient load is written into its cell when it is accepted; a sample passes through
// a full turn of the cell ring past the single multiply-accumulate, a drain of the product
// register, a rounding into the output register (held while that is full) and the transfer
// reset clears the delay line cells, tap_count to 1 and all control state
// in_stall is high while a sample is in flight, also while its sum waits on a full output
// register; one finished result may wait at the output while the next sample runs
module fir_sample_filter #(
	parameter int MAX_TAPS = fsf_pkg::MAX_TAPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic        [fsf_pkg::INDEX_W-1:0]   coef_index,
	input  logic signed [fsf_pkg::COEF_W-1:0]    coef_value,
	input  logic signed [fsf_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fsf_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                 clipped,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [fsf_pkg::CFG_W-1:0]     cfg_data
);
	import fsf_pkg::*;

	localparam int CNT_W = $clog2(MAX_TAPS);
	localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;
	localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
	localparam int RND_W = ACC_W - 15;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TAPS - 1);
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1 << 14);
	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
	localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-32768);

	typedef enum logic [1:0] {IDLE, RUN, DRAIN, FINISH} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [CFG_W-1:0]           tap_count_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       clipped_q;

	logic                       accept;
	logic                       active;
	logic                       slot_free;
	cell_ctl_t                  cell_ctl;
	mac_ctl_t                   mac_ctl;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    biased;
	logic signed [RND_W-1:0]    rnd;
	logic signed [SAMPLE_W-1:0] sat_val;
	logic                       sat_clip;

	logic signed [SAMPLE_W-1:0] smp [MAX_TAPS];
	logic signed [COEF_W-1:0]   tap [MAX_TAPS];

	assign in_stall  = (state_q != IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || !out_stall;

	// tap count of zero still uses tap 0; counts above the ring clamp naturally
	assign active = (cnt_q == '0) || (CMP_W'(cnt_q) < CMP_W'(tap_count_q));

	always_comb begin
		cell_ctl.load   = accept && (req_type == REQ_LOAD);
		cell_ctl.shift  = accept && (req_type == REQ_FILTER);
		cell_ctl.rotate = (state_q == RUN);
		mac_ctl.clear   = cell_ctl.shift;
		mac_ctl.take    = (state_q == RUN) && active;
	end

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		localparam int NXT = (k + 1) % MAX_TAPS;
		logic signed [SAMPLE_W-1:0] prev;
		if (k == 0) begin : g_head
			assign prev = sample_in;
		end else begin : g_body
			assign prev = smp[k-1];
		end
		fsf_cell #(
			.CELL_IDX (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.coef_index (coef_index),
			.coef_value (coef_value),
			.smp_prev   (prev),
			.smp_next   (smp[NXT]),
			.tap_next   (tap[NXT]),
			.smp        (smp[k]),
			.tap        (tap[k])
		);
	end

	fsf_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.tap    (tap[0]),
		.smp    (smp[0]),
		.acc    (acc)
	);

	// round half up, then saturate to q1.15
	always_comb begin
		biased = acc + HALF;
		rnd    = $signed(biased[ACC_W-1:15]);
		if (rnd > SAT_HI) begin
			sat_val  = SAT_HI[SAMPLE_W-1:0];
			sat_clip = 1'b1;
		end else if (rnd < SAT_LO) begin
			sat_val  = SAT_LO[SAMPLE_W-1:0];
			sat_clip = 1'b1;
		end else begin
			sat_val  = rnd[SAMPLE_W-1:0];
			sat_clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			cnt_q        <= '0;
			tap_count_q  <= CFG_W'(1);
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
			clipped_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tap_count_q <= cfg_data;
			end
			// in finish the output register is refilled below
			if (out_valid_q && !out_stall && state_q != FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (cell_ctl.shift) begin
						state_q <= RUN;
						cnt_q   <= '0;
					end
				end
				RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					state_q <= FINISH;
				end
				FINISH: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						sample_out_q <= sat_val;
						clipped_q    <= sat_clip;
						state_q      <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

`ifndef SYNTHESIS
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == FINISH))
		else $error("result appeared without a finished sum");

	a_sample_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_FILTER) |=> (state_q == RUN && cnt_q == '0))
		else $error("sample transfer did not start the ring pass");

	a_drain_after_full_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DRAIN) |-> $past(state_q == RUN && cnt_q == CNT_LAST))
		else $error("drain entered before a full turn of the ring");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_LOAD) |=> (state_q == IDLE))
		else $error("coefficient load left the idle state");
`endif

endmodule

@@ rtl/fsf_cell.sv @@
module fsf_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fsf_pkg::cell_ctl_t                   ctl,
	input  logic        [fsf_pkg::INDEX_W-1:0]   coef_index,
	input  logic signed [fsf_pkg::COEF_W-1:0]    coef_value,
	input  logic signed [fsf_pkg::SAMPLE_W-1:0]  smp_prev,
	input  logic signed [fsf_pkg::SAMPLE_W-1:0]  smp_next,
	input  logic signed [fsf_pkg::COEF_W-1:0]    tap_next,
	output logic signed [fsf_pkg::SAMPLE_W-1:0]  smp,
	output logic signed [fsf_pkg::COEF_W-1:0]    tap
);
	import fsf_pkg::*;

	logic signed [SAMPLE_W-1:0] smp_q;
	logic signed [COEF_W-1:0]   tap_q;
	logic                       hit;

	assign hit = (32'(coef_index) == 32'(CELL_IDX));

	// delay line entry, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q <= '0;
		end else if (ctl.shift) begin
			smp_q <= smp_prev;
		end else if (ctl.rotate) begin
			smp_q <= smp_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && hit) begin
			tap_q <= coef_value;
		end else if (ctl.rotate) begin
			tap_q <= tap_next;
		end
	end

	assign smp = smp_q;
	assign tap = tap_q;

endmodule

@@ rtl/fsf_mac.sv @@
module fsf_mac #(
	parameter int ACC_W = 40
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fsf_pkg::mac_ctl_t                    ctl,
	input  logic signed [fsf_pkg::COEF_W-1:0]    tap,
	input  logic signed [fsf_pkg::SAMPLE_W-1:0]  smp,
	output logic signed [ACC_W-1:0]              acc
);
	import fsf_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     take_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(tap) * PROD_W'(smp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1 <= 1'b0;
		end else begin
			take_s1 <= ctl.take && !ctl.clear;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (take_s1) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
	end

	assign acc = acc_q;

endmodule
